/* hw/rtl/cdpt_pkg.sv */
// shared constants, types and codes for the cyclic dma position tracker
`default_nettype none
package cdpt_pkg;

  // ring geometry
  localparam int NUM_SLOTS   = 32;
  localparam int SLOT_BYTES  = 4096;
  localparam int SLOT_FRAMES = SLOT_BYTES / 4;
  localparam int SLOT_SHIFT  = $clog2(SLOT_BYTES);
  localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
  localparam int POS_W       = $clog2(NUM_SLOTS * SLOT_BYTES);

  // field and state widths
  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 5;
  localparam int FRAMES_W    = 16;
  localparam int LINK_W      = 32;
  localparam int TAKE_W      = 11;
  localparam int CUR_W       = 5;
  localparam int PLAYED_W    = 48;
  localparam int STAMP_W     = 36;
  localparam int UNDERRUN_W  = 16;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_DEVICE_PRESENT = '0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_POLL   = 3'd0,
    ACT_FILL   = 3'd1,
    ACT_EXTEND = 3'd2,
    ACT_PLAY   = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_DONE   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_APPLY
  } ctl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic sample;
    logic apply;
  } ctl_cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/cyclic_dma_position_tracker.sv */
// top level of the cyclic dma position tracker
//
// usage:
//   input channel (in_valid / in_stall) carries one driver action per item:
//   action, slot index, offered frame count and the raw link position.
//   result channel (out_valid / out_stall) returns exactly one item per
//   input item: accepted frames, done answer and the tracker status after
//   the action (current slot, played bytes, underruns, running flag).
//   the apb port holds one register, device_present at byte address 0;
//   while it is 0 every action is ignored and only the status and done answer are reported.
// timing:
//   an item passes capture, sample (position unwrap and stamp
//   read) and apply (compare and state update). the result register
//   is loaded at apply, and the next item is taken only once the
//   controller's capture / sample / apply sequence is back in idle.
// reset: rst_n clears all stamps, counters, the running flag and the
//   device_present register; no clearing pass is needed.
// stall: a held result stays in the output register; the block still
//   accepts and samples the next item, then waits before applying it.
`default_nettype none
module cyclic_dma_position_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cdpt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cdpt_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cdpt_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cdpt_pkg::ACTION_W-1:0]       in_action,
  input  logic [cdpt_pkg::INDEX_W-1:0]        in_index,
  input  logic [cdpt_pkg::FRAMES_W-1:0]       in_frame_count,
  input  logic [cdpt_pkg::LINK_W-1:0]         in_link_position,
  // result items
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cdpt_pkg::TAKE_W-1:0]         out_take_frames,
  output logic                                out_finished,
  output logic [cdpt_pkg::CUR_W-1:0]          out_current_index,
  output logic [cdpt_pkg::PLAYED_W-1:0]       out_played_bytes,
  output logic [cdpt_pkg::UNDERRUN_W-1:0]     out_underrun_count,
  output logic                                out_engine_running
);

  cdpt_pkg::ctl_cmd_t cmd;
  logic               device_present_r, device_present_nxt;
  logic               cfg_wr;
  logic               cfg_hit;

  // register decode: word index sits above the byte offset
  assign cfg_hit    = (cfg_paddr[cdpt_pkg::CFG_ADDR_W-1:2] == cdpt_pkg::REG_DEVICE_PRESENT);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = cfg_hit ? cdpt_pkg::CFG_DATA_W'(device_present_r) : '0;

  assign device_present_nxt = (cfg_wr && cfg_hit) ? cfg_pwdata[0] : device_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_present_r <= 1'b0;
    end else begin
      device_present_r <= device_present_nxt;
    end
  end

  // sequencing
  cdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // state and arithmetic
  cdpt_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .device_present     (device_present_r),
    .in_action          (in_action),
    .in_index           (in_index),
    .in_frame_count     (in_frame_count),
    .in_link_position   (in_link_position),
    .out_take_frames    (out_take_frames),
    .out_finished       (out_finished),
    .out_current_index  (out_current_index),
    .out_played_bytes   (out_played_bytes),
    .out_underrun_count (out_underrun_count),
    .out_engine_running (out_engine_running)
  );

  // one item in flight: the port closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is still in flight");

  // a stopped engine reports slot zero
  a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_engine_running) |-> (out_current_index == '0))
    else $error("current slot nonzero while engine stopped");

  // a fill never takes more than one slot of frames
  a_take_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_take_frames) <= cdpt_pkg::SLOT_FRAMES))
    else $error("accepted frames exceed slot size");

endmodule
`default_nettype wire

/* hw/rtl/cdpt_ctrl.sv */
// sequencing state machine: capture, sample, apply, result hand-off
`default_nettype none
module cdpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output cdpt_pkg::ctl_cmd_t  cmd
);

  cdpt_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      cdpt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = cdpt_pkg::ST_SAMPLE;
        end
      end
      cdpt_pkg::ST_SAMPLE: begin
        cmd.sample = 1'b1;
        state_nxt  = cdpt_pkg::ST_APPLY;
      end
      cdpt_pkg::ST_APPLY: begin
        // commit only once the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.apply = 1'b1;
          state_nxt = cdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cdpt_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.apply | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hw/rtl/cdpt_datapath.sv */
// tracker state, position unwrap, slot stamps and result registers
`default_nettype none
module cdpt_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cdpt_pkg::ctl_cmd_t                    cmd,
  input  logic                                  device_present,
  input  logic [cdpt_pkg::ACTION_W-1:0]         in_action,
  input  logic [cdpt_pkg::INDEX_W-1:0]          in_index,
  input  logic [cdpt_pkg::FRAMES_W-1:0]         in_frame_count,
  input  logic [cdpt_pkg::LINK_W-1:0]           in_link_position,
  output logic [cdpt_pkg::TAKE_W-1:0]           out_take_frames,
  output logic                                  out_finished,
  output logic [cdpt_pkg::CUR_W-1:0]            out_current_index,
  output logic [cdpt_pkg::PLAYED_W-1:0]         out_played_bytes,
  output logic [cdpt_pkg::UNDERRUN_W-1:0]       out_underrun_count,
  output logic                                  out_engine_running
);

  // captured item
  logic [cdpt_pkg::ACTION_W-1:0]   act_r;
  logic [cdpt_pkg::INDEX_W-1:0]    idx_r;
  logic [cdpt_pkg::FRAMES_W-1:0]   frames_r;
  logic [cdpt_pkg::POS_W-1:0]      link_pos_r;

  // tracker state
  logic [cdpt_pkg::POS_W-1:0]      wp_r, wp_nxt;
  logic [cdpt_pkg::PLAYED_W-1:0]   played_r, played_nxt;
  logic [cdpt_pkg::STAMP_W-1:0]    fc_r, fc_nxt;
  logic [cdpt_pkg::STAMP_W-1:0]    stamp_r   [cdpt_pkg::NUM_SLOTS];
  logic [cdpt_pkg::STAMP_W-1:0]    stamp_nxt [cdpt_pkg::NUM_SLOTS];
  logic [cdpt_pkg::STAMP_W-1:0]    decl_r, decl_nxt;
  logic                            running_r, running_nxt;
  logic [cdpt_pkg::UNDERRUN_W-1:0] underrun_r, underrun_nxt;

  // sample stage results
  logic [cdpt_pkg::POS_W-1:0]      samp_pos_r;
  logic [cdpt_pkg::PLAYED_W-1:0]   samp_played_r;
  logic [cdpt_pkg::STAMP_W-1:0]    sel_stamp_r;

  // result registers
  logic [cdpt_pkg::TAKE_W-1:0]     res_take_r;
  logic                            res_fin_r;
  logic [cdpt_pkg::CUR_W-1:0]      res_cur_r;
  logic [cdpt_pkg::PLAYED_W-1:0]   res_played_r;
  logic [cdpt_pkg::UNDERRUN_W-1:0] res_underrun_r;
  logic                            res_running_r;

  logic                            idx_ok;
  logic [cdpt_pkg::SLOT_IDX_W-1:0] slot, slot_next;
  logic                            do_sample;
  logic [cdpt_pkg::POS_W-1:0]      delta;
  logic [cdpt_pkg::PLAYED_W:0]     sum;
  logic [cdpt_pkg::PLAYED_W-1:0]   sum_sat;
  logic [cdpt_pkg::PLAYED_W-1:0]   sel_end, decl_end;
  logic [cdpt_pkg::TAKE_W-1:0]     take_calc, take;
  logic                            fin;
  logic [cdpt_pkg::CUR_W-1:0]      cur;

  assign idx_ok    = int'(idx_r) < cdpt_pkg::NUM_SLOTS;
  assign slot      = cdpt_pkg::SLOT_IDX_W'(idx_r);
  assign slot_next = (slot == cdpt_pkg::SLOT_IDX_W'(cdpt_pkg::NUM_SLOTS - 1)) ?
                     '0 : slot + 1'b1;

  // position unwrap: ring length is a power of two, so the wrap is a plain subtract
  assign do_sample = device_present && running_r &&
                     ((act_r == cdpt_pkg::ACT_POLL) ||
                      (((act_r == cdpt_pkg::ACT_EXTEND) || (act_r == cdpt_pkg::ACT_DONE))
                       && idx_ok));
  assign delta   = link_pos_r - wp_r;
  assign sum     = {1'b0, played_r} + (cdpt_pkg::PLAYED_W + 1)'(delta);
  assign sum_sat = sum[cdpt_pkg::PLAYED_W] ? '1 : sum[cdpt_pkg::PLAYED_W-1:0];

  assign sel_end  = cdpt_pkg::PLAYED_W'({sel_stamp_r, {cdpt_pkg::SLOT_SHIFT{1'b0}}});
  assign decl_end = cdpt_pkg::PLAYED_W'({decl_r, {cdpt_pkg::SLOT_SHIFT{1'b0}}});

  assign take_calc = (int'(frames_r) < cdpt_pkg::SLOT_FRAMES) ?
                     cdpt_pkg::TAKE_W'(frames_r) : cdpt_pkg::TAKE_W'(cdpt_pkg::SLOT_FRAMES);

  always_comb begin
    wp_nxt       = wp_r;
    played_nxt   = played_r;
    fc_nxt       = fc_r;
    stamp_nxt    = stamp_r;
    decl_nxt     = decl_r;
    running_nxt  = running_r;
    underrun_nxt = underrun_r;
    take         = '0;
    fin          = (act_r == cdpt_pkg::ACT_DONE);
    if (device_present) begin
      unique case (act_r)
        cdpt_pkg::ACT_POLL: begin
          wp_nxt     = samp_pos_r;
          played_nxt = samp_played_r;
        end
        cdpt_pkg::ACT_FILL: begin
          if (idx_ok) begin
            take = take_calc;
            if (take_calc != '0) begin
              fc_nxt = (fc_r == '1) ? fc_r : fc_r + 1'b1;
              stamp_nxt[slot]      = fc_nxt;
              stamp_nxt[slot_next] = '0;
            end
          end
        end
        cdpt_pkg::ACT_EXTEND: begin
          if (idx_ok) begin
            wp_nxt     = samp_pos_r;
            played_nxt = samp_played_r;
            if (running_r && (samp_played_r > decl_end) && (underrun_r != '1)) begin
              underrun_nxt = underrun_r + 1'b1;
            end
            decl_nxt = sel_stamp_r;
          end
        end
        cdpt_pkg::ACT_PLAY: begin
          if (idx_ok) begin
            fc_nxt = cdpt_pkg::STAMP_W'(idx_r) + 1'b1;
            for (int i = 0; i < cdpt_pkg::NUM_SLOTS; i++) begin
              stamp_nxt[i] = (i <= int'(idx_r)) ? cdpt_pkg::STAMP_W'(i + 1) : '0;
            end
            decl_nxt     = cdpt_pkg::STAMP_W'(idx_r) + 1'b1;
            wp_nxt       = '0;
            played_nxt   = '0;
            underrun_nxt = '0;
            running_nxt  = 1'b1;
          end
        end
        cdpt_pkg::ACT_STOP: begin
          running_nxt = 1'b0;
          for (int i = 0; i < cdpt_pkg::NUM_SLOTS; i++) begin
            stamp_nxt[i] = '0;
          end
          fc_nxt   = '0;
          decl_nxt = '0;
        end
        cdpt_pkg::ACT_DONE: begin
          if (running_r && idx_ok) begin
            wp_nxt     = samp_pos_r;
            played_nxt = samp_played_r;
            fin        = (sel_stamp_r == '0) || (samp_played_r >= sel_end);
          end
        end
        default: begin
        end
      endcase
    end
    cur = (device_present && running_nxt) ?
          cdpt_pkg::CUR_W'(wp_nxt[cdpt_pkg::POS_W-1:cdpt_pkg::SLOT_SHIFT]) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r      <= in_action;
      idx_r      <= in_index;
      frames_r   <= in_frame_count;
      link_pos_r <= in_link_position[cdpt_pkg::POS_W-1:0];
    end
    if (cmd.sample) begin
      samp_pos_r    <= do_sample ? link_pos_r : wp_r;
      samp_played_r <= do_sample ? sum_sat : played_r;
      sel_stamp_r   <= stamp_r[slot];
    end
    if (cmd.apply) begin
      res_take_r     <= take;
      res_fin_r      <= fin;
      res_cur_r      <= cur;
      res_played_r   <= played_nxt;
      res_underrun_r <= underrun_nxt;
      res_running_r  <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      played_r   <= '0;
      fc_r       <= '0;
      decl_r     <= '0;
      running_r  <= 1'b0;
      underrun_r <= '0;
      for (int i = 0; i < cdpt_pkg::NUM_SLOTS; i++) begin
        stamp_r[i] <= '0;
      end
    end else if (cmd.apply) begin
      wp_r       <= wp_nxt;
      played_r   <= played_nxt;
      fc_r       <= fc_nxt;
      decl_r     <= decl_nxt;
      running_r  <= running_nxt;
      underrun_r <= underrun_nxt;
      stamp_r    <= stamp_nxt;
    end
  end

  assign out_take_frames    = res_take_r;
  assign out_finished       = res_fin_r;
  assign out_current_index  = res_cur_r;
  assign out_played_bytes   = res_played_r;
  assign out_underrun_count = res_underrun_r;
  assign out_engine_running = res_running_r;

endmodule
`default_nettype wire

/* dv/cdpt_position_checker.sv */
// checker for the cyclic dma position tracker: status prediction and result comparison
`timescale 1ns / 100ps
module cdpt_position_checker
  import cdpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [INDEX_W-1:0]    in_index,
  input  logic [FRAMES_W-1:0]   in_frame_count,
  input  logic [LINK_W-1:0]     in_link_position,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [TAKE_W-1:0]     out_take_frames,
  input  logic                  out_finished,
  input  logic [CUR_W-1:0]      out_current_index,
  input  logic [PLAYED_W-1:0]   out_played_bytes,
  input  logic [UNDERRUN_W-1:0] out_underrun_count,
  input  logic                  out_engine_running,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  localparam longint unsigned RING_BYTES = NUM_SLOTS * SLOT_BYTES;
  localparam logic [PLAYED_W-1:0]   PLAYED_MAX   = '1;
  localparam logic [STAMP_W-1:0]    STAMP_MAX    = '1;
  localparam logic [UNDERRUN_W-1:0] UNDERRUN_MAX = '1;

  typedef struct packed {
    logic [TAKE_W-1:0]     take_frames;
    logic                  finished;
    logic [CUR_W-1:0]      current_index;
    logic [PLAYED_W-1:0]   played_bytes;
    logic [UNDERRUN_W-1:0] underrun_count;
    logic                  engine_running;
  } status_t;

  // tracker state as the block should hold it
  logic                  present;
  logic [POS_W-1:0]      ring_pos;
  logic [PLAYED_W-1:0]   played;
  logic [STAMP_W-1:0]    fill_no;
  logic [STAMP_W-1:0]    stamp [NUM_SLOTS];
  logic [STAMP_W-1:0]    last_declared;
  logic                  running;
  logic [UNDERRUN_W-1:0] underruns;

  status_t     status_due [$];
  int unsigned fail_total = 0;

  function automatic void unwrap_position(input logic [LINK_W-1:0] raw);
    longint unsigned pos, delta, sum;
    if (!running) return;
    pos = raw % RING_BYTES;
    if (pos >= ring_pos) delta = pos - ring_pos;
    else delta = RING_BYTES - ring_pos + pos;
    sum = played + delta;
    played = (sum > PLAYED_MAX) ? PLAYED_MAX : PLAYED_W'(sum);
    ring_pos = POS_W'(pos);
  endfunction

  function automatic status_t step_tracker(input logic [ACTION_W-1:0] act,
                                           input logic [INDEX_W-1:0]  slot,
                                           input logic [FRAMES_W-1:0] frames,
                                           input logic [LINK_W-1:0]   link);
    status_t         r;
    bit              in_ring;
    longint unsigned end_bytes;
    r = '0;
    in_ring = (slot < NUM_SLOTS);
    r.finished = (act == ACT_DONE);
    if (present) begin
      case (act)
        ACT_POLL: unwrap_position(link);
        ACT_FILL: begin
          if (in_ring) begin
            r.take_frames = (frames < SLOT_FRAMES) ? TAKE_W'(frames) : TAKE_W'(SLOT_FRAMES);
            if (r.take_frames != 0) begin
              if (fill_no != STAMP_MAX) fill_no++;
              stamp[slot] = fill_no;
              stamp[(int'(slot) + 1) % NUM_SLOTS] = '0;
            end
          end
        end
        ACT_EXTEND: begin
          if (in_ring) begin
            unwrap_position(link);
            if (running && played > 64'(last_declared) * SLOT_BYTES &&
                underruns != UNDERRUN_MAX)
              underruns++;
            last_declared = stamp[slot];
          end
        end
        ACT_PLAY: begin
          if (in_ring) begin
            fill_no = STAMP_W'(slot) + 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++)
              stamp[i] = (i <= int'(slot)) ? STAMP_W'(i + 1) : '0;
            last_declared = STAMP_W'(slot) + 1'b1;
            ring_pos = '0;
            played = '0;
            underruns = '0;
            running = 1'b1;
          end
        end
        ACT_STOP: begin
          running = 1'b0;
          for (int i = 0; i < NUM_SLOTS; i++) stamp[i] = '0;
          fill_no = '0;
          last_declared = '0;
        end
        ACT_DONE: begin
          if (running && in_ring) begin
            unwrap_position(link);
            end_bytes = 64'(stamp[slot]) * SLOT_BYTES;
            r.finished = (end_bytes == 0 || played >= end_bytes);
          end
        end
        default: ;
      endcase
      if (running) r.current_index = CUR_W'((ring_pos / SLOT_BYTES) % NUM_SLOTS);
    end
    r.played_bytes = played;
    r.underrun_count = underruns;
    r.engine_running = running;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin : track
    status_t want;
    if (!rst_n) begin
      present = 1'b0;
      ring_pos = '0;
      played = '0;
      fill_no = '0;
      for (int i = 0; i < NUM_SLOTS; i++) stamp[i] = '0;
      last_declared = '0;
      running = 1'b0;
      underruns = '0;
      status_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_DEVICE_PRESENT)
        present = cfg_pwdata[0];
      if (in_valid && !in_stall)
        status_due.push_back(step_tracker(in_action, in_index, in_frame_count,
                                          in_link_position));
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $display("%0t: result item with nothing expected", $time);
          fail_total++;
        end else begin
          want = status_due.pop_front();
          check_field("take_frames", want.take_frames, out_take_frames);
          check_field("finished", want.finished, out_finished);
          check_field("current_index", want.current_index, out_current_index);
          check_field("played_bytes", want.played_bytes, out_played_bytes);
          check_field("underrun_count", want.underrun_count, out_underrun_count);
          check_field("engine_running", want.engine_running, out_engine_running);
        end
      end
    end
    mismatches <= fail_total;
    pending <= status_due.size();
  end

endmodule

/* dv/tb_cyclic_dma_position_tracker.sv */
// testbench top for the cyclic dma position tracker: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_cyclic_dma_position_tracker;
  import cdpt_pkg::*;

  // byte address of device_present on the apb port
  localparam logic [CFG_ADDR_W-1:0] PRESENT_ADDR = {REG_DEVICE_PRESENT, 2'b00};
  // action codes the block leaves undefined
  localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int RING_BYTES     = NUM_SLOTS * SLOT_BYTES;
  localparam int SETTLE_CYCLES  = 8;     // margin after the last result is back
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_A_ITEMS  = 470;
  localparam int TOTAL_ITEMS    = 950;
  localparam int QUIET_ITEMS    = 100;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ACTION_W-1:0]   in_action = '0;
  logic [INDEX_W-1:0]    in_index = '0;
  logic [FRAMES_W-1:0]   in_frame_count = '0;
  logic [LINK_W-1:0]     in_link_position = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TAKE_W-1:0]     out_take_frames;
  logic                  out_finished;
  logic [CUR_W-1:0]      out_current_index;
  logic [PLAYED_W-1:0]   out_played_bytes;
  logic [UNDERRUN_W-1:0] out_underrun_count;
  logic                  out_engine_running;

  int unsigned mismatches;
  int unsigned pending;

  // idling knobs, changed per playback session; quiet turns all idling off
  bit          quiet = 1'b0;
  int unsigned gap_pct = 10;
  int unsigned stall_pct = 10;
  int          sent = 0;
  int          idle_cycles = 0;
  // where the modeled dma engine is inside the ring
  logic [POS_W-1:0] engine_pos = '0;

  cyclic_dma_position_tracker uut (.*);

  cdpt_position_checker track_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure: stall bursts of random length
  initial begin : result_backpressure
    int hold;
    forever begin
      @(posedge clk);
      if (quiet || stall_pct == 0 || $urandom_range(99, 0) >= stall_pct) begin
        out_stall <= 1'b0;
      end else begin
        hold = $urandom_range(19, 1);
        out_stall <= 1'b1;
        repeat (hold - 1) @(posedge clk);
      end
    end
  end

  // a stretch with no handshake at all means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_cyclic_dma_position_tracker NOT OK");
      $finish;
    end
  end

  // one item on the input channel; valid stays high after acceptance so a
  // back-to-back item only changes the payload
  task automatic issue_action(input logic [ACTION_W-1:0] act,
                              input logic [INDEX_W-1:0]  slot,
                              input logic [FRAMES_W-1:0] frames,
                              input logic [LINK_W-1:0]   link);
    if (!quiet && gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_index <= slot;
    in_frame_count <= frames;
    in_link_position <= link;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // apb write: setup then access, committed when pready is seen
  task automatic write_present(input logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= PRESENT_ADDR;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // link position as the driver reads it: ring offset in the low bits,
  // garbage above that the block has to reduce away
  function automatic logic [LINK_W-1:0] engine_link();
    logic [LINK_W-1:0] raw;
    raw = $urandom();
    raw[POS_W-1:0] = engine_pos;
    return raw;
  endfunction

  // a playback session: play, then fills in ring order mixed with polls, extends,
  // done queries, reserved codes, stops and restarts while the engine moves on, then stop
  task automatic run_session(input int budget);
    int                  len, k, pick, roll;
    logic [INDEX_W-1:0]  fill_slot, last_fill;
    logic [FRAMES_W-1:0] frames;
    len = $urandom_range(80, 20);
    stall_pct = $urandom_range(2, 0) * 12;
    gap_pct = $urandom_range(2, 0) * 15;
    fill_slot = INDEX_W'($urandom());
    issue_action(ACT_PLAY, fill_slot, FRAMES_W'($urandom()), $urandom());
    engine_pos = '0;
    last_fill = fill_slot;
    fill_slot = fill_slot + 1'b1;
    for (k = 0; k < len && sent < budget; k++) begin
      // engine advance: mostly within a couple of slots, sometimes most of the ring
      roll = $urandom_range(99, 0);
      if (roll < 55) engine_pos = engine_pos + POS_W'($urandom_range(2 * SLOT_BYTES, 0));
      else if (roll < 85) engine_pos = engine_pos + POS_W'($urandom_range(255, 0));
      else engine_pos = engine_pos + POS_W'($urandom_range(RING_BYTES - 1, 0));
      // offered frames: empty, exactly one slot, over a slot, partial
      roll = $urandom_range(99, 0);
      if (roll < 10) frames = '0;
      else if (roll < 35) frames = FRAMES_W'(SLOT_FRAMES);
      else if (roll < 50) frames = FRAMES_W'($urandom_range(65535, SLOT_FRAMES + 1));
      else if (roll < 60) frames = '1;
      else frames = FRAMES_W'($urandom_range(SLOT_FRAMES - 1, 1));
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
        issue_action(ACT_POLL, INDEX_W'($urandom()), FRAMES_W'($urandom()), engine_link());
      end else if (pick < 45) begin
        issue_action(ACT_FILL, fill_slot, frames, $urandom());
        if (frames != 0) begin
          last_fill = fill_slot;
          fill_slot = fill_slot + 1'b1;
        end
      end else if (pick < 58) begin
        issue_action(ACT_EXTEND, (pick < 55) ? last_fill : INDEX_W'($urandom()),
                     FRAMES_W'($urandom()), engine_link());
      end else if (pick < 80) begin
        issue_action(ACT_DONE, (pick < 69) ? last_fill : INDEX_W'($urandom()),
                     FRAMES_W'($urandom()), engine_link());
      end else if (pick < 85) begin
        issue_action((pick % 2) ? ACT_RSVD6 : ACT_RSVD7, INDEX_W'($urandom()),
                     FRAMES_W'($urandom()), $urandom());
      end else if (pick < 88) begin
        issue_action(ACT_STOP, INDEX_W'($urandom()), FRAMES_W'($urandom()), $urandom());
      end else if (pick < 91) begin
        // restart in the middle of a session
        fill_slot = INDEX_W'($urandom());
        issue_action(ACT_PLAY, fill_slot, FRAMES_W'($urandom()), $urandom());
        engine_pos = '0;
        last_fill = fill_slot;
        fill_slot = fill_slot + 1'b1;
      end else begin
        issue_action(ACT_POLL, INDEX_W'($urandom()), FRAMES_W'($urandom()), engine_link());
      end
    end
    issue_action(ACT_STOP, INDEX_W'($urandom()), FRAMES_W'($urandom()), $urandom());
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // controller absent: every action ignored, done still answers finished
    write_present(32'hFFFF_FFFE);
    issue_action(ACT_POLL, 5'd0, 16'h0000, 32'hFFFF_FFFF);
    issue_action(ACT_PLAY, 5'd5, 16'h0001, 32'h0000_0000);
    issue_action(ACT_FILL, 5'd31, 16'hFFFF, 32'h1234_5678);
    issue_action(ACT_EXTEND, 5'd3, 16'h0400, 32'h0001_0000);
    issue_action(ACT_DONE, 5'd3, 16'h0000, 32'h0000_8000);
    issue_action(ACT_STOP, 5'd0, 16'h0000, 32'h0000_0000);
    issue_action(ACT_RSVD7, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    settle();

    // controller present, directed corner cases
    write_present(32'h0000_0001);
    issue_action(ACT_DONE, 5'd0, 16'h0000, 32'h0000_0000);      // done while stopped
    issue_action(ACT_POLL, 5'd0, 16'h0000, 32'hFFFF_FFFF);      // no sample while stopped
    issue_action(ACT_PLAY, 5'd31, 16'h0000, 32'h0000_0000);     // play up to the last slot
    issue_action(ACT_POLL, 5'd0, 16'h0000, 32'hFFFF_FFFF);      // ring end
    issue_action(ACT_POLL, 5'd0, 16'h0000, 32'h0000_0000);      // wrap by one byte
    issue_action(ACT_FILL, 5'd31, 16'hFFFF, 32'h0000_0000);     // clamp, clears slot 0
    issue_action(ACT_FILL, 5'd0, 16'h0000, 32'h0000_0000);      // empty fill
    issue_action(ACT_FILL, 5'd0, 16'h0401, 32'h0000_0000);      // one frame over a slot
    issue_action(ACT_FILL, 5'd1, 16'h0001, 32'h0000_0000);      // single frame
    issue_action(ACT_FILL, 5'd2, 16'h0400, 32'h0000_0000);      // exactly a slot
    issue_action(ACT_DONE, 5'd3, 16'h0000, 32'h0000_0000);      // slot cleared by the last fill
    issue_action(ACT_DONE, 5'd2, 16'h0000, 32'h0001_2345);
    issue_action(ACT_EXTEND, 5'd31, 16'h0000, 32'hABCD_2345);   // played past last fill
    issue_action(ACT_RSVD6, 5'd7, 16'h1234, 32'h0000_4000);
    issue_action(ACT_RSVD7, 5'd8, 16'h4321, 32'h0000_4000);
    issue_action(ACT_STOP, 5'd0, 16'h0000, 32'h0000_0000);
    issue_action(ACT_POLL, 5'd0, 16'h0000, 32'h0000_7000);      // stopped, position kept
    issue_action(ACT_DONE, 5'd4, 16'h0000, 32'h0000_7000);      // done after stop
    issue_action(ACT_PLAY, 5'd0, 16'h0000, 32'h0000_0000);
    issue_action(ACT_FILL, 5'd1, 16'd100, 32'h0000_0000);
    issue_action(ACT_DONE, 5'd1, 16'h0000, 32'h0000_0100);      // not yet played
    issue_action(ACT_EXTEND, 5'd1, 16'h0000, 32'h0000_3000);    // underrun in a fresh sound
    issue_action(ACT_STOP, 5'd0, 16'h0000, 32'h0000_0000);

    // random playback sessions
    while (sent < PHASE_A_ITEMS) run_session(PHASE_A_ITEMS);
    settle();

    // controller gone again: random noise must change nothing
    write_present(32'h0000_0000);
    repeat (30) issue_action(ACTION_W'($urandom()), INDEX_W'($urandom()),
                             FRAMES_W'($urandom()), $urandom());
    settle();

    write_present(32'hFFFF_FFFF);
    while (sent < TOTAL_ITEMS - QUIET_ITEMS) run_session(TOTAL_ITEMS - QUIET_ITEMS);
    // last stretch runs at full rate on both sides
    quiet = 1'b1;
    while (sent < TOTAL_ITEMS) run_session(TOTAL_ITEMS);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb_cyclic_dma_position_tracker OK");
    else
      $display("tb_cyclic_dma_position_tracker NOT OK");
    $finish;
  end

endmodule

/* cyclic_dma_position_tracker.f */
hw/rtl/cdpt_pkg.sv
hw/rtl/cdpt_ctrl.sv
hw/rtl/cdpt_datapath.sv
hw/rtl/cyclic_dma_position_tracker.sv
dv/cdpt_position_checker.sv
dv/tb_cyclic_dma_position_tracker.sv
